// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/dfsu_pkg.sv
// Types and constants of the delimiter field splitter.
package dfsu_pkg;

	localparam int unsigned MAX_DELIM_DEF = 8;
	localparam int unsigned DELIM_BYTES   = 8;
	localparam int unsigned CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_EMPTY  = 2'd2;

	typedef struct packed {
		logic sel_new;
		logic load;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       field_end;
		logic       string_done;
		logic       run_last;
	} res_t;

endpackage

// File: rtl/dfsu_cell.sv
// One window cell: holds a byte, compares it against its delimiter byte.
module dfsu_cell (
	input  logic                 clk,
	input  dfsu_pkg::cell_ctl_t  ctl,
	input  logic [7:0]           in_byte,
	input  logic [7:0]           delim_byte,
	input  logic [7:0]           right_cand,
	output logic [7:0]           cand,
	output logic                 eq
);
	import dfsu_pkg::*;

	logic [7:0] byte_q;

	assign cand = ctl.sel_new ? in_byte : byte_q;
	assign eq   = (cand == delim_byte);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= right_cand;
		end else if (ctl.load) begin
			byte_q <= in_byte;
		end
	end

endmodule

// File: rtl/dfsu_out_fifo.sv
// Two-entry result queue between the window logic and the output port.
module dfsu_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dfsu_pkg::res_t push_res,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output dfsu_pkg::res_t out_res
);
	import dfsu_pkg::*;

	res_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic       do_push;

	assign room      = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_res   = slot_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign do_push   = push && room;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/delimiter_field_splitter_unit.sv
// Delimiter field splitter: splits a byte stream into fields at a configured delimiter
// of up to eight bytes, found leftmost first without overlap. Bytes sit in a row of
// window cells until a full-length compare shows they do not start a match. Items
// without string end are taken back to back while the result queue has room and no
// flush runs. A string-end item that closes a field starts a flush that emits each byte
// still held in the window (at most one less than the effective delimiter length, so at
// most seven) and then the closing field end; the flush drains through cell 0 one byte a
// cycle while the queue has room, and new items wait meanwhile. A string-end item that
// closes nothing starts no flush. Results pass through a two-entry queue. Configuration
// writes are accepted in any cycle; issue them only while no item is in flight.
module delimiter_field_splitter_unit #(
	parameter int unsigned MAX_DELIM = dfsu_pkg::MAX_DELIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // in_byte
	input  logic [0:0]                     s_tuser,   // byte_present
	input  logic                           s_tlast,   // string_end
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // out_byte
	output logic [2:0]                     m_tuser,   // byte_valid, field_end, string_done
	output logic                           m_tlast,   // run_last
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dfsu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data
);
	import dfsu_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_DELIM + 1);

	logic [3:0]       delim_len_q;
	logic [63:0]      delim_bytes_q;
	logic             keep_empty_q;
	logic [CNT_W-1:0] count_q;
	logic             nonempty_q;
	logic             flush_q;

	logic [4:0]       len_wide;
	logic [CNT_W-1:0] len;
	logic             take;
	logic             cfg_take;
	logic             present_go;
	logic             full;
	logic             hit;
	logic             flush_go;
	logic             flush_byte;
	logic             shift_all;
	logic             fe_emit;
	logic             room;
	logic             push;
	res_t             push_res;
	res_t             out_res;
	logic [CNT_W-1:0] count_n;
	logic             nonempty_n;

	logic [7:0]         cand   [MAX_DELIM];
	logic [MAX_DELIM-1:0] eq;
	logic [MAX_DELIM-1:0] mask;

	always_comb begin
		len_wide = {1'b0, delim_len_q};
		if (len_wide > 5'(DELIM_BYTES)) begin
			len_wide = 5'(DELIM_BYTES);
		end
		if (len_wide > 5'(MAX_DELIM)) begin
			len_wide = 5'(MAX_DELIM);
		end
	end
	assign len = CNT_W'(len_wide);

	assign cfg_ready  = 1'b1;
	assign cfg_take   = cfg_valid && cfg_ready;
	assign s_tready   = !flush_q && room;
	assign take       = s_tvalid && s_tready;
	assign present_go = take && s_tuser[0] && (len != '0);
	assign full       = present_go && (count_q == len - 1'b1);
	assign hit        = &(eq | ~mask);
	assign flush_go   = flush_q && room;
	assign flush_byte = flush_go && (count_q != '0);
	assign shift_all  = (full && !hit) || flush_byte;

	for (genvar i = 0; i < MAX_DELIM; i++) begin : g_cell
		cell_ctl_t  ctl;
		logic [7:0] dbyte;
		logic [7:0] right;

		assign ctl.sel_new = present_go && (count_q == CNT_W'(i));
		assign ctl.load    = present_go && !full && (count_q == CNT_W'(i));
		assign ctl.shift   = shift_all;
		assign mask[i]     = (CNT_W'(i) < len);

		if (i < DELIM_BYTES) begin : g_db
			assign dbyte = delim_bytes_q[8*i +: 8];
		end else begin : g_nodb
			assign dbyte = 8'h00;
		end

		if (i == MAX_DELIM - 1) begin : g_end
			assign right = 8'h00;
		end else begin : g_mid
			assign right = cand[i+1];
		end

		dfsu_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.in_byte    (s_tdata),
			.delim_byte (dbyte),
			.right_cand (right),
			.cand       (cand[i]),
			.eq         (eq[i])
		);
	end

	always_comb begin
		count_n    = count_q;
		nonempty_n = nonempty_q;
		if (take && s_tuser[0] && (len == '0)) begin
			nonempty_n = 1'b1;
		end else if (full && hit) begin
			nonempty_n = 1'b0;
			count_n    = '0;
		end else if (full) begin
			nonempty_n = 1'b1;
		end else if (present_go) begin
			count_n = count_q + 1'b1;
		end
	end

	assign fe_emit = (len == '0) || keep_empty_q || nonempty_n || (count_n != '0);

	always_comb begin
		push     = 1'b0;
		push_res = '0;
		if (take) begin
			push_res.run_last = !(s_tlast && fe_emit);
			if (s_tuser[0] && (len == '0)) begin
				push                = 1'b1;
				push_res.out_byte   = s_tdata;
				push_res.byte_valid = 1'b1;
			end else if (full && hit) begin
				push               = keep_empty_q || nonempty_q;
				push_res.field_end = 1'b1;
			end else if (full) begin
				push                = 1'b1;
				push_res.out_byte   = cand[0];
				push_res.byte_valid = 1'b1;
			end
		end else if (flush_byte) begin
			push                = 1'b1;
			push_res.out_byte   = cand[0];
			push_res.byte_valid = 1'b1;
		end else if (flush_go) begin
			push                 = 1'b1;
			push_res.field_end   = 1'b1;
			push_res.string_done = 1'b1;
			push_res.run_last    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_len_q   <= '0;
			delim_bytes_q <= '0;
			keep_empty_q  <= 1'b0;
			count_q       <= '0;
			nonempty_q    <= 1'b0;
			flush_q       <= 1'b0;
		end else if (cfg_take) begin
			unique case (cfg_index)
				REG_DELIM_LEN: begin
					delim_len_q <= cfg_data[3:0];
					count_q     <= '0;
					nonempty_q  <= 1'b0;
				end
				REG_DELIM_BYTES: begin
					delim_bytes_q <= cfg_data;
					count_q       <= '0;
					nonempty_q    <= 1'b0;
				end
				REG_KEEP_EMPTY: begin
					keep_empty_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end else if (take) begin
			count_q    <= count_n;
			nonempty_q <= s_tlast ? 1'b0 : nonempty_n;
			flush_q    <= s_tlast && fe_emit;
		end else if (flush_byte) begin
			count_q <= count_q - 1'b1;
		end else if (flush_go) begin
			flush_q <= 1'b0;
		end
	end

	dfsu_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = out_res.out_byte;
	assign m_tuser = {out_res.string_done, out_res.field_end, out_res.byte_valid};
	assign m_tlast = out_res.run_last;

endmodule

// File: rtl/dfsu_checker.sv
// Port-level checks of the delimiter field splitter, bound to the top level.
`include "assert_macros.svh"

module dfsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [2:0] m_tuser,
	input logic       m_tlast
);

	`ASSERT_IMPL(a_one_kind, clk, arst_n, m_tvalid, m_tuser[0] != m_tuser[1])
	`ASSERT_IMPL(a_done_closes, clk, arst_n, m_tvalid && m_tuser[2], m_tuser[1] && m_tlast)
	`ASSERT_IMPL(a_end_zero, clk, arst_n, m_tvalid && m_tuser[1], m_tdata == 8'h00)
	`ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

endmodule

bind delimiter_field_splitter_unit dfsu_checker u_dfsu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
